/* rtl/lsdt_pkg.sv */
// shared widths, types and constants of the lru stack depth tracker
`default_nettype none

package lsdt_pkg;

    // fixed field widths of the channel words
    localparam int PAGE_IN_W = 32;
    localparam int DEPTH_W   = 6;
    localparam int CAP_W     = 7;

    // saturation value of the reported depth
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 6'd63;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic [PAGE_IN_W-1:0] page_in_t;
    typedef logic [DEPTH_W-1:0]   depth_t;
    typedef logic [CAP_W-1:0]     cap_t;

endpackage : lsdt_pkg

`default_nettype wire

/* rtl/lsdt_access_if.sv */
// channel interfaces: memory reference words in, depth result words out
`default_nettype none

interface lsdt_access_if
    import lsdt_pkg::*;
;
    logic     valid;
    logic     ready;
    page_in_t page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface : lsdt_access_if

interface lsdt_result_if
    import lsdt_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   fault;
    depth_t depth;

    modport source (output valid, output fault, output depth, input ready);
    modport sink   (input valid, input fault, input depth, output ready);
endinterface : lsdt_result_if

`default_nettype wire

/* rtl/lru_stack_depth_tracker_unit.sv */
// top level: lru stack depth tracker with a streaming search and reorder pass
//
//   channel   dir   handshake        word
//   access    in    valid / ready    page_number[31:0]
//   result    out   valid / ready    fault, depth[5:0]
//   cfg       in    cfg_we           cfg_wdata[6:0] = capacity
//
// the time from one accept to the next grows with the entries visited:
// a miss reads all occupancy entries; a hit at depth d stops there.
// one memory read per visited entry, set by the single read port of the stack.
// each read entry is written back one place deeper in the same pass, so search
// and move to top finish together. reset empties the stack; no clearing pass.
// access.ready is low while an item is in work; a full result register holds
// the sequencer in its last step until the word is taken.
`default_nettype none

module lru_stack_depth_tracker_unit
    import lsdt_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int PAGE_BITS   = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    lsdt_access_if.sink       access,
    lsdt_result_if.source     result
);

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int OW   = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = ((OW > CAP_W) ? OW : CAP_W) + 1;
    localparam int DXW  = (AW > DEPTH_W) ? AW : DEPTH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CAP_W-1:0]     capacity_reg;
    logic [OW-1:0]        occupancy_reg, occupancy_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [PAGE_BITS-1:0] carry_reg, carry_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 fault_reg, fault_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [PAGE_BITS-1:0] mem_rdata;

    logic                 accept;
    logic                 match;
    logic                 last_entry;
    logic                 room;
    logic                 out_free;
    logic [DXW-1:0]       idx_ext;

    lsdt_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (PAGE_BITS),
        .ADDR_W (AW)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (carry_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // handshake and status terms
    assign access.ready = (state_reg == S_IDLE);
    assign accept       = access.valid && access.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign match        = (mem_rdata == page_reg);
    assign last_entry   = ((CMPW'(idx_reg) + CMPW'(1)) == CMPW'(occupancy_reg));
    assign room         = ((CMPW'(occupancy_reg) + CMPW'(1)) <= CMPW'(capacity_reg))
                          && (CMPW'(occupancy_reg) < CMPW'(STACK_DEPTH));
    assign idx_ext      = DXW'(idx_reg);

    // memory addressing: read runs one entry ahead of the write back
    always_comb
    begin
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        case (state_reg)
            S_SCAN:
            begin
                mem_raddr = idx_reg + AW'(1);
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
            end
            S_POST:
            begin
                mem_we    = !hit_reg && room;
                mem_waddr = occupancy_reg[AW-1:0];
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        occupancy_next = occupancy_reg;
        idx_next       = idx_reg;
        page_next      = page_reg;
        carry_next     = carry_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        fault_next     = fault_reg;
        depth_next     = depth_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    page_next  = PAGE_BITS'(access.page_number);
                    carry_next = PAGE_BITS'(access.page_number);
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if (occupancy_reg == '0)
                    begin
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // entry idx is written with the one above it; stop on a match
                carry_next = mem_rdata;
                if (match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_POST;
                end
                else if (last_entry)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fault_next     = !hit_reg;
                    if (hit_reg)
                    begin
                        depth_next = (idx_ext > DXW'(DEPTH_MAX)) ? DEPTH_MAX
                                                                 : idx_ext[DEPTH_W-1:0];
                    end
                    else
                    begin
                        depth_next = '0;
                        if (room)
                        begin
                            occupancy_next = occupancy_reg + OW'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            occupancy_reg <= occupancy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        page_reg  <= page_next;
        carry_reg <= carry_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
        depth_reg <= depth_next;
    end

    // result word
    assign result.valid = out_valid_reg;
    assign result.fault = fault_reg;
    assign result.depth = depth_reg;

endmodule : lru_stack_depth_tracker_unit

`default_nettype wire

/* rtl/lsdt_stack_mem.sv */
// simple dual port stack memory, one write and one registered read per cycle
`default_nettype none

module lsdt_stack_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : lsdt_stack_mem

`default_nettype wire
